@@ rtl/murmur3_hash32_stream_top_defines.svh @@
// Assertion macros for the hash block's RTL; mh3_ctrl includes them.
// Depends on nothing; users must have clk and rst in scope.
`ifndef MURMUR3_HASH32_STREAM_TOP_DEFINES_SVH
`define MURMUR3_HASH32_STREAM_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MH3_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mh3 assertion failed");

// Next-cycle implication, disabled during reset.
`define MH3_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mh3 assertion failed");

`endif

@@ rtl/mh3_pkg.sv @@
// Package for the streamed 32-bit hash: constants, sequencer states,
// and the command/status structs between controller and datapath.
package mh3_pkg;

  localparam logic [31:0] MH3_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MH3_C2 = 32'h1b873593;
  localparam logic [31:0] MH3_N  = 32'he6546b64;
  localparam logic [31:0] MH3_F1 = 32'h85ebca6b;
  localparam logic [31:0] MH3_F2 = 32'hc2b2ae35;

  localparam logic [2:0] MH3_FULL_WORD = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX1,
    ST_MIX2,
    ST_FOLD,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3
  } mh3_state_t;

  typedef struct packed {
    logic load;   // capture request fields
    logic start;  // first word of a message: reload seed, clear length
    logic mix1;
    logic mix2;
    logic fold;
    logic fin1;
    logic fin2;
    logic fin3;   // write result register
  } mh3_cmd_t;

  typedef struct packed {
    logic last;
  } mh3_status_t;

endpackage

@@ rtl/mh3_datapath.sv @@
// Datapath of the streamed hash: seed, accumulator, length, one shared
// multiply register and the result register. Depends on mh3_pkg.
module mh3_datapath import mh3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_write,
  input  logic [31:0] hash_seed,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count_in_word,
  input  logic        last_word,
  input  mh3_cmd_t    cmd,
  output mh3_status_t status,
  output logic [31:0] hash_value
);

  logic [31:0] seed;
  logic [31:0] acc;
  logic [31:0] len;
  logic [31:0] word;
  logic [31:0] prod;
  logic [2:0]  cnt;
  logic        last;

  logic [2:0]  cnt_in;
  logic [31:0] word_in;
  logic [31:0] len_base;
  logic [31:0] h_x;
  logic [31:0] h_rot;
  logic [31:0] acc_next;
  logic [31:0] fin_t;
  logic [31:0] prod_next;

  always_comb begin
    cnt_in = (byte_count_in_word > MH3_FULL_WORD) ? MH3_FULL_WORD : byte_count_in_word;
    unique case (cnt_in)
      3'd1:    word_in = {24'h0, data_word[7:0]};
      3'd2:    word_in = {16'h0, data_word[15:0]};
      3'd3:    word_in = {8'h0, data_word[23:0]};
      3'd4:    word_in = data_word;
      default: word_in = 32'h0;
    endcase
    len_base = cmd.start ? 32'h0 : len;
  end

  // fold: for a non-empty word xor the mixed word, then for a full word rotl 13, times 5, plus N
  always_comb begin
    h_x   = acc ^ prod;
    h_rot = {h_x[18:0], h_x[31:19]};
    if (cnt == MH3_FULL_WORD) begin
      acc_next = {h_rot[29:0], 2'b00} + h_rot + MH3_N;
    end else if (cnt != 3'd0) begin
      acc_next = h_x;
    end else begin
      acc_next = acc;
    end
  end

  always_comb begin
    fin_t     = acc ^ len;
    prod_next = prod;
    priority if (cmd.mix1) begin
      prod_next = word * MH3_C1;
    end else if (cmd.mix2) begin
      prod_next = {prod[16:0], prod[31:17]} * MH3_C2;
    end else if (cmd.fin1) begin
      prod_next = (fin_t ^ {16'h0, fin_t[31:16]}) * MH3_F1;
    end else if (cmd.fin2) begin
      prod_next = (prod ^ {13'h0, prod[31:13]}) * MH3_F2;
    end else begin
      prod_next = prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 32'h0;
    end else if (seed_write) begin
      seed <= hash_seed;
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    if (cmd.load) begin
      word <= word_in;
      cnt  <= cnt_in;
      last <= last_word;
      len  <= len_base + {29'h0, cnt_in};
      if (cmd.start) begin
        acc <= seed;
      end
    end
    if (cmd.fold) begin
      acc <= acc_next;
    end
    if (cmd.fin3) begin
      hash_value <= prod ^ {16'h0, prod[31:16]};
    end
  end

  assign status.last = last;

endmodule

@@ rtl/mh3_ctrl.sv @@
// Sequencer for the streamed hash: steps one request through mix, fold
// and, for a last word, finalize, and owns the handshakes. Depends on mh3_pkg and the defines.
`include "murmur3_hash32_stream_top_defines.svh"

module mh3_ctrl import mh3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  output logic        hash_valid,
  input  logic        hash_ready,
  input  mh3_status_t status,
  output mh3_cmd_t    cmd
);

  mh3_state_t state, state_next;
  logic       in_message;
  logic       out_free;

  assign out_free   = !hash_valid || hash_ready;
  assign data_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      in_message <= 1'b0;
      hash_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        in_message <= 1'b1;
      end else if (cmd.fold && status.last) begin
        in_message <= 1'b0;
      end
      if (cmd.fin3) begin
        hash_valid <= 1'b1;
      end else if (hash_ready) begin
        hash_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (data_valid) begin
          cmd.load   = 1'b1;
          cmd.start  = !in_message;
          state_next = ST_MIX1;
        end
      end
      ST_MIX1: begin
        cmd.mix1   = 1'b1;
        state_next = ST_MIX2;
      end
      ST_MIX2: begin
        cmd.mix2   = 1'b1;
        state_next = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = status.last ? ST_FIN1 : ST_IDLE;
      end
      ST_FIN1: begin
        cmd.fin1   = 1'b1;
        state_next = ST_FIN2;
      end
      ST_FIN2: begin
        cmd.fin2   = 1'b1;
        state_next = ST_FIN3;
      end
      ST_FIN3: begin
        // hold until the result register is free
        if (out_free) begin
          cmd.fin3   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `MH3_ASSERT_NXT(a_accept_starts_mix, data_valid && data_ready, state == ST_MIX1)
  `MH3_ASSERT_NXT(a_last_ends_message, state == ST_FOLD && status.last,
                  state == ST_FIN1 && !in_message)
  `MH3_ASSERT_NXT(a_fin_holds_when_full, state == ST_FIN3 && !out_free, state == ST_FIN3)
  `MH3_ASSERT_IMP(a_no_load_midway, state != ST_IDLE, !cmd.load)

endmodule

@@ rtl/murmur3_hash32_stream_top.sv @@
// Channel    | Direction | Signals
// data in    | in        | data_valid/data_ready, data_word, byte_count_in_word, last_word
// hash out   | out       | hash_valid/hash_ready, hash_value
// seed cfg   | in        | seed_write, hash_seed
//
// A word that is not last passes two registered multiply steps for the word
// mix, then the fold, before data_ready returns. A last word goes through the
// mix, the fold and three finalize steps, and waits longer if the
// previous result is still waiting in the output register.
// Reset is synchronous; it clears the seed to zero and the message state.
// Top level of the streamed 32-bit hash. Depends on mh3_pkg, mh3_ctrl,
// mh3_datapath.
module murmur3_hash32_stream_top import mh3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_write,
  input  logic [31:0] hash_seed,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count_in_word,
  input  logic        last_word,
  output logic        hash_valid,
  input  logic        hash_ready,
  output logic [31:0] hash_value
);

  mh3_cmd_t    cmd;
  mh3_status_t status;

  mh3_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_ready (data_ready),
    .hash_valid (hash_valid),
    .hash_ready (hash_ready),
    .status     (status),
    .cmd        (cmd)
  );

  mh3_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .seed_write         (seed_write),
    .hash_seed          (hash_seed),
    .data_word          (data_word),
    .byte_count_in_word (byte_count_in_word),
    .last_word          (last_word),
    .cmd                (cmd),
    .status             (status),
    .hash_value         (hash_value)
  );

endmodule

@@ sim/murmur3_hash32_stream_top_test.sv @@
// Testbench for murmur3_hash32_stream_top: a directed table, then random messages.
// Random idling is applied on both handshakes. Every hash is checked against a
// predictor or, for typed rows, a typed value. Depends only on the RTL of the hash block.
`timescale 1ns / 1ps

module murmur3_hash32_stream_top_test;

  localparam logic [31:0] BLOCK_MUL1 = 32'hcc9e2d51;
  localparam logic [31:0] BLOCK_MUL2 = 32'h1b873593;
  localparam logic [31:0] FOLD_ADD   = 32'he6546b64;
  localparam logic [31:0] AVAL_MUL1  = 32'h85ebca6b;
  localparam logic [31:0] AVAL_MUL2  = 32'hc2b2ae35;
  localparam logic [2:0]  FULL_WORD  = 3'd4;

  localparam int TOTAL_WORDS    = 1550;
  localparam int MAX_WAIT       = 18;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 600;
  localparam int SHOWN_ERRORS   = 10;
  localparam int NUM_ROWS       = 18;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        seed_write = 1'b0;
  logic [31:0] hash_seed = '0;
  logic        data_valid = 1'b0;
  logic        data_ready;
  logic [31:0] data_word = '0;
  logic [2:0]  byte_count_in_word = '0;
  logic        last_word = 1'b0;
  logic        hash_valid;
  logic        hash_ready = 1'b0;
  logic [31:0] hash_value;

  murmur3_hash32_stream_top DUT (
    .clk                (clk),
    .rst                (rst),
    .seed_write         (seed_write),
    .hash_seed          (hash_seed),
    .data_valid         (data_valid),
    .data_ready         (data_ready),
    .data_word          (data_word),
    .byte_count_in_word (byte_count_in_word),
    .last_word          (last_word),
    .hash_valid         (hash_valid),
    .hash_ready         (hash_ready),
    .hash_value         (hash_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted hash state, advanced as each request is accepted.
  logic [31:0] seed_reg = '0;
  logic [31:0] running_hash = '0;
  logic [31:0] byte_total = '0;
  logic        msg_open = 1'b0;
  logic [31:0] expected_hashes[$];

  bit send_burst = 1'b0;
  int words_sent = 0;
  int hashes_checked = 0;
  int seeds_written = 0;
  int hash_errors = 0;
  int quiet_cycles = 0;

  typedef struct packed {
    logic        write_seed;
    logic [31:0] seed;
    logic [31:0] word;
    logic [2:0]  count;
    logic        is_last;
    logic        typed;
    logic [31:0] hash;
  } directed_row_t;

  // A typed hash is used where the value is known by inspection; other rows
  // are checked against the predictor.
  directed_row_t directed_rows [0:NUM_ROWS-1] = '{
    '{1'b0, 32'h0,        32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0000_0000}, // empty message
    '{1'b0, 32'h0,        32'hFFFF_FF00, 3'd1, 1'b1, 1'b1, 32'h514E_28B7}, // one zero byte
    '{1'b1, 32'h1,        32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, 32'h514E_28B7}, // empty, seed 1
    '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd4, 1'b0, 1'b0, 32'h0},
    '{1'b0, 32'h0,        32'h0000_0000, 3'd4, 1'b0, 1'b0, 32'h0},
    '{1'b0, 32'h0,        32'h8765_4321, 3'd3, 1'b1, 1'b0, 32'h0},
    '{1'b0, 32'h0,        32'hDEAD_BEEF, 3'd5, 1'b0, 1'b0, 32'h0},   // counts above four
    '{1'b0, 32'h0,        32'h1234_5678, 3'd6, 1'b0, 1'b0, 32'h0},
    '{1'b0, 32'h0,        32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0, 32'h0},
    '{1'b0, 32'h0,        32'hA5A5_A5A5, 3'd2, 1'b0, 1'b0, 32'h0},   // short word that is not last
    '{1'b0, 32'h0,        32'hFFFF_FFFF, 3'd0, 1'b0, 1'b0, 32'h0},   // empty word mid-message
    '{1'b0, 32'h0,        32'h5A5A_5A5A, 3'd4, 1'b0, 1'b0, 32'h0},
    '{1'b1, 32'h1234_5678, 32'h0102_0304, 3'd1, 1'b1, 1'b0, 32'h0},  // seed change mid-message
    '{1'b0, 32'h0,        32'h0000_0000, 3'd4, 1'b1, 1'b0, 32'h0},
    '{1'b0, 32'h0,        32'hFFFF_FFFF, 3'd3, 1'b1, 1'b0, 32'h0},
    '{1'b0, 32'h0,        32'h0000_FFFF, 3'd2, 1'b1, 1'b0, 32'h0},
    '{1'b1, 32'h0,        32'h8000_0000, 3'd4, 1'b0, 1'b0, 32'h0},
    '{1'b0, 32'h0,        32'h0000_0001, 3'd4, 1'b1, 1'b0, 32'h0}
  };

  function automatic logic [31:0] scramble_block(input logic [31:0] k);
    logic [31:0] t;
    t = k * BLOCK_MUL1;
    t = {t[16:0], t[31:17]};
    return t * BLOCK_MUL2;
  endfunction

  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * AVAL_MUL1;
    t = t ^ (t >> 13);
    t = t * AVAL_MUL2;
    return t ^ (t >> 16);
  endfunction

  task automatic absorb_word(input logic [31:0] w, input logic [2:0] c, input logic is_last);
    logic [31:0] h;
    logic [31:0] mask;
    logic [2:0]  n;
    n = (c > FULL_WORD) ? FULL_WORD : c;
    if (!msg_open) begin
      running_hash = seed_reg;
      byte_total = '0;
      msg_open = 1'b1;
    end
    h = running_hash;
    if (n == FULL_WORD) begin
      h = h ^ scramble_block(w);
      h = {h[18:0], h[31:19]};
      h = h * 32'd5 + FOLD_ADD;
    end else if (n != 3'd0) begin
      // drop bytes above the valid count
      mask = (32'd1 << (8 * n)) - 32'd1;
      h = h ^ scramble_block(w & mask);
    end
    byte_total = byte_total + 32'(n);
    if (!is_last) begin
      running_hash = h;
    end else begin
      expected_hashes.push_back(avalanche(h ^ byte_total));
      running_hash = seed_reg;
      byte_total = '0;
      msg_open = 1'b0;
    end
  endtask

  task automatic send_request(input logic [31:0] w, input logic [2:0] c, input logic is_last,
                              input logic typed, input logic [31:0] typed_hash);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      data_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data_valid <= 1'b1;
    data_word <= w;
    byte_count_in_word <= c;
    last_word <= is_last;
    do @(posedge clk); while (!data_ready);
    absorb_word(w, c, is_last);
    if (typed && is_last)
      expected_hashes[expected_hashes.size() - 1] = typed_hash;
    words_sent++;
  endtask

  task automatic hold_until_drained();
    data_valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    // let a word with no result finish before touching the seed
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] v);
    hold_until_drained();
    seed_write <= 1'b1;
    hash_seed <= v;
    @(posedge clk);
    seed_write <= 1'b0;
    seed_reg = v;
    seeds_written++;
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic note_error(input string what, input logic [31:0] want, input logic [31:0] got);
    hash_errors++;
    if (hash_errors <= SHOWN_ERRORS)
      $display("%t: %s: expected %08h got %08h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin : check_hash
    logic [31:0] want;
    if (!rst && hash_valid && hash_ready) begin
      hashes_checked++;
      if (expected_hashes.size() == 0) begin
        note_error("hash with none pending", 32'h0, hash_value);
      end else begin
        want = expected_hashes.pop_front();
        if (hash_value !== want)
          note_error("hash mismatch", want, hash_value);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (data_valid && data_ready) || (hash_valid && hash_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin : receiver
    int stall;
    bit take_burst;
    take_burst = 1'b0;
    forever begin
      if ($urandom_range(0, 15) == 0)
        take_burst = !take_burst;
      stall = take_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall != 0) begin
        hash_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      hash_ready <= 1'b1;
      do @(posedge clk); while (!hash_valid);
    end
  end

  initial begin : sender
    int len;
    int i;
    bit broken;
    logic is_last;
    logic [2:0] cnt;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].write_seed)
        write_seed(directed_rows[r].seed);
      send_request(directed_rows[r].word, directed_rows[r].count, directed_rows[r].is_last,
                   directed_rows[r].typed, directed_rows[r].hash);
    end

    // Mostly well-formed messages; some carry short or oversized counts mid-message.
    while (words_sent < TOTAL_WORDS) begin
      if ($urandom_range(0, 39) == 0)
        write_seed(pick_seed());
      if ($urandom_range(0, 49) == 0)
        hold_until_drained();
      send_burst = ($urandom_range(0, 7) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      broken = ($urandom_range(0, 7) == 0);
      for (i = 0; i < len; i++) begin
        is_last = (i == len - 1);
        cnt = is_last ? 3'($urandom_range(0, 4)) : FULL_WORD;
        if (broken && $urandom_range(0, 3) == 0)
          cnt = 3'($urandom_range(0, 7));
        send_request($urandom, cnt, is_last, 1'b0, 32'h0);
      end
    end

    send_burst = 1'b0;
    hold_until_drained();
    $display("Run: %0d words sent, %0d hashes checked, %0d seed writes",
             words_sent, hashes_checked, seeds_written);
    $display("Covered counts 0 to 7, short and empty words mid-message, seed extremes");
    if (hash_errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ murmur3_hash32_stream_top.f @@
+incdir+rtl
rtl/mh3_pkg.sv
rtl/mh3_datapath.sv
rtl/mh3_ctrl.sv
rtl/murmur3_hash32_stream_top.sv
sim/murmur3_hash32_stream_top_test.sv
